### rtl/core/vlcp_pkg.sv
// ----------------------------------------------------------------------------
// vlcp_pkg
// Shared widths, codes and the tag type for the cell placement pipeline.
// ----------------------------------------------------------------------------
package vlcp_pkg;

  localparam int DIM_W = 14;
  localparam int IDX_W = 7;
  localparam int CNT_W = 7;
  localparam int POS_W = 22;
  localparam int QW    = 14;
  localparam int NUM_W = 29;
  localparam int DEN_W = 15;

  // largest surface or picture dimension; wider values saturate to it
  localparam int MAX_DIM = 8192;

  localparam logic [DIM_W-1:0] POS_MAX = 14'h3FFF;
  localparam int LINE_ZOOM_MIN = 6;
  localparam int SINGLE_SHRINK = 16;
  localparam int SINGLE_OFFSET = 8;

  localparam logic [1:0] MODE_GRID      = 2'd0;
  localparam logic [1:0] MODE_ONE_BIG   = 2'd1;
  localparam logic [1:0] MODE_BIG_SMALL = 2'd2;

  typedef enum logic [1:0] {
    REG_LAYOUT    = 2'd0,
    REG_SURF_W    = 2'd1,
    REG_SURF_H    = 2'd2,
    REG_SRC_COUNT = 2'd3
  } vlcp_reg_t;

  typedef enum logic [1:0] {
    ST_PLACED     = 2'd0,
    ST_SURF_ZERO  = 2'd1,
    ST_CELL_EMPTY = 2'd2
  } vlcp_status_t;

  typedef struct packed {
    logic [POS_W-1:0] cx;
    logic [POS_W-1:0] cy;
    logic [DIM_W-1:0] cw;
    logic [DIM_W-1:0] ch;
    logic             wfix;
    logic             zero_pic;
    vlcp_status_t     status;
  } vlcp_tag_t;

endpackage

### rtl/core/vlcp_div.sv
// ----------------------------------------------------------------------------
// vlcp_div
// Restoring divider, one quotient bit per register stage, with a tag word
// carried alongside so the fitted size meets its placement at the end.
// ----------------------------------------------------------------------------
module vlcp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [vlcp_pkg::NUM_W-1:0] in_num,
  input  logic [vlcp_pkg::DEN_W-1:0] in_den,
  input  vlcp_pkg::vlcp_tag_t       in_tag,
  output logic                      out_valid,
  output logic [vlcp_pkg::QW-1:0]   out_q,
  output vlcp_pkg::vlcp_tag_t       out_tag
);
  import vlcp_pkg::*;

  logic             vld_r [QW];
  logic [NUM_W-1:0] rem_r [QW];
  logic [DEN_W-1:0] den_r [QW];
  logic [QW-1:0]    q_r   [QW];
  vlcp_tag_t        tag_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic             vld_in;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QW-1:0]    q_in;
    vlcp_tag_t        tag_in;
    logic [NUM_W-1:0] sh;
    logic             ge;
    logic [NUM_W-1:0] rem_nxt;
    logic [QW-1:0]    q_nxt;

    if (s == 0) begin : g_head
      assign vld_in = in_valid;
      assign rem_in = in_num;
      assign den_in = in_den;
      assign q_in   = '0;
      assign tag_in = in_tag;
    end else begin : g_body
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    always_comb begin
      sh      = NUM_W'(den_in) << B;
      ge      = rem_in >= sh;
      rem_nxt = ge ? rem_in - sh : rem_in;
      q_nxt   = q_in | (QW'(ge) << B);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
      rem_r[s] <= rem_nxt;
      den_r[s] <= den_in;
      q_r[s]   <= q_nxt;
      tag_r[s] <= tag_in;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule

### rtl/core/video_layout_cell_placement.sv
// ----------------------------------------------------------------------------
// video_layout_cell_placement
// Fits one source picture into its layout cell and centers it there.
// ----------------------------------------------------------------------------
// One request is taken every clock (busy never rises) and its placement comes
// out as a one-cycle out_valid strobe; the receiver cannot stall. A request
// passes five front stages (capture, cell size by reciprocal multiply,
// remainders, products, branch select), the 14-stage bit-per-stage divider
// that rounds the fitted dimension and a registered output stage.
// Configuration writes are always taken (cfg_ready is high) and are meant
// for when no request is in flight.
module video_layout_cell_placement #(
  parameter int MAX_SOURCES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [vlcp_pkg::IDX_W-1:0] in_slot_index,
  input  logic [vlcp_pkg::DIM_W-1:0] in_pic_width,
  input  logic [vlcp_pkg::DIM_W-1:0] in_pic_height,
  input  logic                       in_rotated,
  output logic                       out_valid,
  output logic [vlcp_pkg::DIM_W-1:0] out_place_x,
  output logic [vlcp_pkg::DIM_W-1:0] out_place_y,
  output logic [vlcp_pkg::DIM_W-1:0] out_place_w,
  output logic [vlcp_pkg::DIM_W-1:0] out_place_h,
  output logic [1:0]                 out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [vlcp_pkg::DIM_W-1:0] cfg_data
);
  import vlcp_pkg::*;

  localparam int ZMAX = (MAX_SOURCES > LINE_ZOOM_MIN) ? MAX_SOURCES : LINE_ZOOM_MIN;
  localparam int ZW   = $clog2(ZMAX + 1);
  localparam int K    = DIM_W + ZW;
  localparam int RW   = K + 1;
  localparam int NMAX = (MAX_SOURCES < 127) ? MAX_SOURCES : 127;
  localparam int LAT  = 4 + QW + 2;
  localparam logic [DIM_W:0] DMAX = (DIM_W+1)'(MAX_DIM);

  // reciprocal table: x / d == (x * rtab[d]) >> K for 14-bit x
  logic [RW-1:0] rtab [ZMAX+1];
  for (genvar g = 0; g <= ZMAX; g++) begin : g_rtab
    localparam longint RV = (g == 0) ? 0 : ((longint'(1) << K) + g - 1) / g;
    assign rtab[g] = RW'(RV);
  end

  function automatic logic [3:0] csqrt(input logic [CNT_W-1:0] n);
    logic [3:0] r;
    r = 4'd12;
    for (int z = 11; z >= 1; z--) begin
      if (8'(n) <= 8'(z * z)) r = 4'(z);
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return ({1'b0, v} > DMAX) ? DIM_W'(DMAX) : v;
  endfunction

  // configuration registers
  logic [1:0]       layout_r;
  logic [DIM_W-1:0] surf_w_r;
  logic [DIM_W-1:0] surf_h_r;
  logic [CNT_W-1:0] src_cnt_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r  <= MODE_GRID;
      surf_w_r  <= '0;
      surf_h_r  <= '0;
      src_cnt_r <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (vlcp_reg_t'(cfg_index))
        REG_LAYOUT:    layout_r  <= cfg_data[1:0];
        REG_SURF_W:    surf_w_r  <= cfg_data;
        REG_SURF_H:    surf_h_r  <= cfg_data;
        REG_SRC_COUNT: src_cnt_r <= cfg_data[CNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // derived layout values; the user keeps them static while requests are in flight (the block does not enforce it)
  logic [DIM_W-1:0] w_sat, h_sat;
  logic             m_big_small, m_one, m_grid;
  logic [CNT_W-1:0] n_cnt;
  logic [ZW-1:0]    zoom;
  logic [RW-1:0]    recip;
  logic             n_one;
  logic             surf_zero;

  always_comb begin
    w_sat       = sat_dim(surf_w_r);
    h_sat       = sat_dim(surf_h_r);
    m_big_small = layout_r == MODE_BIG_SMALL;
    m_one       = layout_r == MODE_ONE_BIG;
    m_grid      = !m_big_small && !m_one;
    if (src_cnt_r == '0) n_cnt = CNT_W'(1);
    else if (src_cnt_r > CNT_W'(NMAX)) n_cnt = CNT_W'(NMAX);
    else n_cnt = src_cnt_r;
    if (m_one) n_cnt = CNT_W'(1);
    if (m_big_small)
      zoom = (n_cnt > CNT_W'(LINE_ZOOM_MIN)) ? ZW'(n_cnt) : ZW'(LINE_ZOOM_MIN);
    else
      zoom = ZW'(csqrt(n_cnt));
    recip     = rtab[zoom];
    n_one     = n_cnt == CNT_W'(1);
    surf_zero = (w_sat == '0) || (h_sat == '0);
  end

  // stage 1: capture, swap for rotation
  logic             v1_r;
  logic [IDX_W-1:0] idx1_r;
  logic [DIM_W-1:0] pw1_r, ph1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start && !busy;
    idx1_r <= in_slot_index;
    pw1_r  <= in_rotated ? sat_dim(in_pic_height) : sat_dim(in_pic_width);
    ph1_r  <= in_rotated ? sat_dim(in_pic_width)  : sat_dim(in_pic_height);
  end

  // stage 2: quotients by zoom
  logic [DIM_W+RW-1:0] mw_nxt, mh_nxt;
  logic [IDX_W+RW-1:0] mi_nxt;
  logic [CNT_W+RW-1:0] mn_nxt, mnm_nxt;
  logic             v2_r;
  logic [IDX_W-1:0] idx2_r, qi2_r;
  logic [DIM_W-1:0] pw2_r, ph2_r, wz2_r, hz2_r;
  logic [CNT_W-1:0] qn2_r, qnm2_r;

  always_comb begin
    mw_nxt  = (DIM_W+RW)'(w_sat) * (DIM_W+RW)'(recip);
    mh_nxt  = (DIM_W+RW)'(h_sat) * (DIM_W+RW)'(recip);
    mi_nxt  = (IDX_W+RW)'(idx1_r) * (IDX_W+RW)'(recip);
    mn_nxt  = (CNT_W+RW)'(n_cnt) * (CNT_W+RW)'(recip);
    mnm_nxt = (CNT_W+RW)'(n_cnt - CNT_W'(1)) * (CNT_W+RW)'(recip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    idx2_r <= idx1_r;
    pw2_r  <= pw1_r;
    ph2_r  <= ph1_r;
    wz2_r  <= mw_nxt[K+DIM_W-1:K];
    hz2_r  <= mh_nxt[K+DIM_W-1:K];
    qi2_r  <= mi_nxt[K+IDX_W-1:K];
    qn2_r  <= mn_nxt[K+CNT_W-1:K];
    qnm2_r <= mnm_nxt[K+CNT_W-1:K];
  end

  // stage 3: cell size, remainders, last-row limit
  logic signed [DIM_W+1:0] cw_s, ch_s;
  logic [IDX_W-1:0] remi_nxt;
  logic [CNT_W-1:0] remn_nxt;
  logic [15:0]      lrl_nxt;
  vlcp_status_t     st3_nxt;
  logic             v3_r;
  logic [IDX_W-1:0] idx3_r, qi3_r, remi3_r;
  logic [CNT_W-1:0] remn3_r;
  logic [15:0]      lrl3_r;
  logic [DIM_W-1:0] pw3_r, ph3_r, hz3_r, cw3_r, ch3_r;
  vlcp_status_t     st3_r;

  always_comb begin
    if (m_big_small && idx2_r == '0) begin
      cw_s = (DIM_W+2)'(w_sat);
      ch_s = (DIM_W+2)'(h_sat) - (DIM_W+2)'(hz2_r);
    end else begin
      cw_s = (DIM_W+2)'(wz2_r);
      ch_s = (DIM_W+2)'(hz2_r);
      if (n_one) begin
        cw_s = cw_s - (DIM_W+2)'(SINGLE_SHRINK);
        ch_s = ch_s - (DIM_W+2)'(SINGLE_SHRINK);
      end
    end
    remi_nxt = idx2_r - IDX_W'(14'(qi2_r) * 14'(zoom));
    remn_nxt = n_cnt - CNT_W'(14'(qn2_r) * 14'(zoom));
    lrl_nxt  = 16'(qnm2_r) * 16'(zoom);
    if (surf_zero) st3_nxt = ST_SURF_ZERO;
    else if (cw_s <= 0 || ch_s <= 0) st3_nxt = ST_CELL_EMPTY;
    else st3_nxt = ST_PLACED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    idx3_r  <= idx2_r;
    qi3_r   <= qi2_r;
    remi3_r <= remi_nxt;
    remn3_r <= remn_nxt;
    lrl3_r  <= lrl_nxt;
    pw3_r   <= pw2_r;
    ph3_r   <= ph2_r;
    hz3_r   <= hz2_r;
    cw3_r   <= cw_s[DIM_W-1:0];
    ch3_r   <= ch_s[DIM_W-1:0];
    st3_r   <= st3_nxt;
  end

  // stage 4: products for position and aspect compare
  logic [IDX_W-1:0] am_nxt;
  logic [CNT_W-1:0] bm_nxt;
  logic             v4_r, idx0_4_r, lr4_r;
  logic [IDX_W+DIM_W-1:0] pa4_r, pb4_r, pc4_r;
  logic [2*DIM_W-1:0]     pwch4_r, phcw4_r;
  logic [DIM_W-1:0] pw4_r, ph4_r, hz4_r, cw4_r, ch4_r;
  vlcp_status_t     st4_r;

  always_comb begin
    am_nxt = m_big_small ? idx3_r - IDX_W'(1) : remi3_r;
    bm_nxt = m_big_small ? n_cnt - CNT_W'(1) : remn3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    idx0_4_r <= idx3_r == '0;
    lr4_r    <= m_grid && remn3_r != '0 && 16'(idx3_r) >= lrl3_r;
    pa4_r    <= (IDX_W+DIM_W)'(am_nxt) * (IDX_W+DIM_W)'(cw3_r);
    pb4_r    <= (IDX_W+DIM_W)'(bm_nxt) * (IDX_W+DIM_W)'(cw3_r);
    pc4_r    <= (IDX_W+DIM_W)'(qi3_r) * (IDX_W+DIM_W)'(ch3_r);
    pwch4_r  <= (2*DIM_W)'(pw3_r) * (2*DIM_W)'(ch3_r);
    phcw4_r  <= (2*DIM_W)'(ph3_r) * (2*DIM_W)'(cw3_r);
    pw4_r    <= pw3_r;
    ph4_r    <= ph3_r;
    hz4_r    <= hz3_r;
    cw4_r    <= cw3_r;
    ch4_r    <= ch3_r;
    st4_r    <= st3_r;
  end

  // stage 5: cell origin, branch select, divider operands
  logic [POS_W-1:0] half_nxt, cx_nxt, cy_nxt;
  logic             ge_nxt;
  logic [2*DIM_W-1:0] a_nxt;
  logic [DIM_W-1:0]   b_nxt;
  logic             v5_r;
  logic [NUM_W-1:0] num5_r;
  logic [DEN_W-1:0] den5_r;
  vlcp_tag_t        tag5_r;

  always_comb begin
    half_nxt = (POS_W'(w_sat) - POS_W'(pb4_r)) >> 1;
    if (m_big_small) begin
      cx_nxt = idx0_4_r ? '0 : POS_W'(pa4_r) + half_nxt;
      cy_nxt = idx0_4_r ? POS_W'(hz4_r) : '0;
    end else begin
      cx_nxt = POS_W'(pa4_r) + (lr4_r ? half_nxt : '0);
      cy_nxt = POS_W'(pc4_r);
      if (n_one) begin
        cx_nxt = cx_nxt + POS_W'(SINGLE_OFFSET);
        cy_nxt = cy_nxt + POS_W'(SINGLE_OFFSET);
      end
    end
    ge_nxt = pwch4_r >= phcw4_r;
    a_nxt  = ge_nxt ? phcw4_r : pwch4_r;
    b_nxt  = ge_nxt ? pw4_r : ph4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    num5_r          <= (NUM_W'(a_nxt) << 1) + NUM_W'(b_nxt);
    den5_r          <= DEN_W'(b_nxt) << 1;
    tag5_r.cx       <= cx_nxt;
    tag5_r.cy       <= cy_nxt;
    tag5_r.cw       <= cw4_r;
    tag5_r.ch       <= ch4_r;
    tag5_r.wfix     <= ge_nxt;
    tag5_r.zero_pic <= pw4_r == '0 && ph4_r == '0;
    tag5_r.status   <= st4_r;
  end

  // rounded fitted dimension
  logic           vq;
  logic [QW-1:0]  q;
  vlcp_tag_t      tq;

  vlcp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v5_r),
    .in_num   (num5_r),
    .in_den   (den5_r),
    .in_tag   (tag5_r),
    .out_valid(vq),
    .out_q    (q),
    .out_tag  (tq)
  );

  // output stage: center in cell, clamp, drop fields on bad status
  logic [DIM_W-1:0] fw_nxt, fh_nxt;
  logic [POS_W-1:0] x_nxt, y_nxt;
  logic             ok_nxt;
  logic             out_valid_r;
  logic [DIM_W-1:0] x_r, y_r, w_r, h_r;
  logic [1:0]       st_r;

  always_comb begin
    if (tq.zero_pic) begin
      fw_nxt = '0;
      fh_nxt = '0;
    end else if (tq.wfix) begin
      fw_nxt = tq.cw;
      fh_nxt = DIM_W'(q);
    end else begin
      fw_nxt = DIM_W'(q);
      fh_nxt = tq.ch;
    end
    x_nxt  = tq.cx + (POS_W'(tq.cw - fw_nxt) >> 1);
    y_nxt  = tq.cy + (POS_W'(tq.ch - fh_nxt) >> 1);
    ok_nxt = tq.status == ST_PLACED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vq;
    x_r  <= !ok_nxt ? '0 : (x_nxt > POS_W'(POS_MAX)) ? POS_MAX : x_nxt[DIM_W-1:0];
    y_r  <= !ok_nxt ? '0 : (y_nxt > POS_W'(POS_MAX)) ? POS_MAX : y_nxt[DIM_W-1:0];
    w_r  <= ok_nxt ? fw_nxt : '0;
    h_r  <= ok_nxt ? fh_nxt : '0;
    st_r <= tq.status;
  end

  assign out_valid   = out_valid_r;
  assign out_place_x = x_r;
  assign out_place_y = y_r;
  assign out_place_w = w_r;
  assign out_place_h = h_r;
  assign out_status  = st_r;

`ifndef SYNTH
  a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("placement word missing at fixed latency");

  a_latency_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LAT !out_valid)
    else $error("spurious placement word");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_PLACED) |->
      (out_place_w == '0 && out_place_h == '0 && out_place_x == '0))
    else $error("fields not cleared on error status");

  a_fit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_PLACED) |->
      ({1'b0, out_place_w} <= DMAX && {1'b0, out_place_h} <= DMAX))
    else $error("fitted size above maximum dimension");
`endif

endmodule
